// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the key matrix block.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge of clk, off while rst is high.
`define KMDES_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property failed");

// Same check on the block's own clock and reset names.
`define KMDES_ASSERT_CLK(label, prop) \
   `KMDES_ASSERT(label, clock, reset, prop)

`endif

// ===== rtl/kmdes_pkg.sv =====
// Package of the key matrix debouncer: command codes, register map, event and
// key entry types. Used by kmdes_key_ram and the top level; depends on nothing.
package kmdes_pkg;

   localparam logic [1:0] CMD_SAMPLE   = 2'd0;
   localparam logic [1:0] CMD_END_PASS = 2'd1;
   localparam logic [1:0] CMD_READ     = 2'd2;

   // Register index is byte address bit 2.
   localparam logic        REG_IDX_LOCKOUT = 1'b0;
   localparam logic [31:0] LOCKOUT_RESET   = 32'd1000;

   typedef struct packed {
      logic [2:0] row;
      logic [2:0] col;
      logic       down;
   } event_type;

   typedef struct packed {
      logic        level;
      logic [63:0] stamp;
   } key_entry_type;

   typedef struct packed {
      logic          en;
      key_entry_type data;
   } key_wr_type;

endpackage

// ===== rtl/kmdes_key_ram.sv =====
// Per-key state memory: debounced level and last change time, one entry per key.
// One registered read port, one write port; uses kmdes_pkg.
module kmdes_key_ram #(
   parameter int  DEPTH = 40,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output kmdes_pkg::key_entry_type      rd_data,
   input  kmdes_pkg::key_wr_type         wr,
   input  logic [AW-1:0]                 wr_addr
);

   kmdes_pkg::key_entry_type key_mem_ff [DEPTH];
   logic [DEPTH-1:0]         valid_ff;
   kmdes_pkg::key_entry_type rd_data_ff;
   logic                     rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem_ff[wr_addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= key_mem_ff[rd_addr];
      end
   end

   // Entries never written read as released with time zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== rtl/key_matrix_debounce_event_stack.sv =====
// Top level of the key matrix debouncer with pending event slot and LIFO stack.
// Depends on kmdes_pkg and kmdes_key_ram.
// Each request beat is a key sample, an end-of-scan-pass mark or a read of the
// pending event, and gives exactly one response beat. A sample changes a key's
// debounced level only when the level differs and (now_us - last change time)
// mod 2^64 is strictly greater than lockout_us; the change makes a down or up
// event that fills the pending slot, or else is pushed on the stack, or is
// dropped (event_dropped) when the stack holds STACK_DEPTH events. An end of
// pass moves the stack top into an empty slot; a read empties the slot.
// Timing: the block takes one request beat per cycle when the response side
// keeps up. An accepted beat goes through stage 1 and the response register,
// and a stalled response holds stage 1. The accepting edge reads the key entry
// (and the stack top); stage 1 compares, updates and writes it back, with the
// entry just written forwarded to an immediately following beat on the same
// key. Key state resets at once through per-entry valid bits, so no clearing
// pass runs after reset. lockout_us is at byte address 0 of the register port;
// the user must write it only while the block is idle; the block does not enforce it.
module key_matrix_debounce_event_stack #(
   parameter int ROWS        = 5,
   parameter int COLS        = 8,
   parameter int STACK_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [2:0]  req_key_row,
   input  logic [2:0]  req_key_col,
   input  logic        req_pressed,
   input  logic [63:0] req_now_us,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_event_pending,
   output logic [2:0]  rsp_event_row,
   output logic [2:0]  rsp_event_col,
   output logic        rsp_event_down,
   output logic        rsp_read_valid,
   output logic [5:0]  rsp_stacked_count,
   output logic        rsp_event_dropped,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int NKEYS = ROWS * COLS;
   localparam int KW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;
   localparam int SW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int FW    = $clog2(STACK_DEPTH + 1);

   // ---------------------------------------------------------------- registers port
   logic [31:0] lockout_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == kmdes_pkg::REG_IDX_LOCKOUT);
   assign csr_prdata = (csr_paddr[2] == kmdes_pkg::REG_IDX_LOCKOUT) ? lockout_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff <= kmdes_pkg::LOCKOUT_RESET;
      end else if (csr_wr) begin
         lockout_ff <= csr_pwdata;
      end
   end

   // ---------------------------------------------------------------- state
   logic                 slot_valid_ff, slot_valid_in;
   kmdes_pkg::event_type slot_ev_ff, slot_ev_in;
   logic [FW-1:0]        fill_ff, fill_in;

   kmdes_pkg::event_type stack_mem_ff [STACK_DEPTH];

   // ---------------------------------------------------------------- stage 0: accept, read
   logic          s1_valid_ff;
   logic          s1_fire;
   logic          req_fire;
   logic          req_in_range;
   logic [KW-1:0] req_kidx;
   logic [SW-1:0] stk_rd_addr;

   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   assign req_in_range = (32'(req_key_row) < ROWS) && (32'(req_key_col) < COLS);
   // Steer out-of-range keys to entry zero; the sample is ignored later.
   assign req_kidx = req_in_range ? KW'(32'(req_key_row) * COLS + 32'(req_key_col)) : '0;

   // Stack top as it stands after the beat now in stage 1 completes.
   assign stk_rd_addr = (fill_in == '0) ? '0 : SW'(fill_in - FW'(1));

   logic [1:0]    s1_cmd_ff;
   logic [2:0]    s1_row_ff;
   logic [2:0]    s1_col_ff;
   logic          s1_pressed_ff;
   logic [63:0]   s1_now_ff;
   logic          s1_in_range_ff;
   logic [KW-1:0] s1_kidx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff      <= req_command;
         s1_row_ff      <= req_key_row;
         s1_col_ff      <= req_key_col;
         s1_pressed_ff  <= req_pressed;
         s1_now_ff      <= req_now_us;
         s1_in_range_ff <= req_in_range;
         s1_kidx_ff     <= req_kidx;
      end
   end

   // ---------------------------------------------------------------- key memory
   kmdes_pkg::key_entry_type key_rd;
   kmdes_pkg::key_wr_type    key_wr;
   kmdes_pkg::key_entry_type kfwd_data_ff;
   logic                     kfwd_valid_ff;

   kmdes_key_ram #(
      .DEPTH (NKEYS)
   ) u_key_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (req_kidx),
      .rd_data (key_rd),
      .wr      (key_wr),
      .wr_addr (s1_kidx_ff)
   );

   // Forward the entry written in the same edge the next beat reads it.
   always_ff @(posedge clock) begin
      if (reset) begin
         kfwd_valid_ff <= 1'b0;
      end else if (req_fire) begin
         kfwd_valid_ff <= key_wr.en && (s1_kidx_ff == req_kidx);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kfwd_data_ff <= key_wr.data;
      end
   end

   // ---------------------------------------------------------------- stack memory
   logic                 stk_push;
   logic                 stk_we;
   kmdes_pkg::event_type new_ev;
   kmdes_pkg::event_type stk_rd_ff;
   kmdes_pkg::event_type sfwd_data_ff;
   logic                 sfwd_valid_ff;

   assign stk_we = s1_fire && stk_push;

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem_ff[SW'(fill_ff)] <= new_ev;
      end
      if (req_fire) begin
         stk_rd_ff    <= stack_mem_ff[stk_rd_addr];
         sfwd_data_ff <= new_ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sfwd_valid_ff <= 1'b0;
      end else if (req_fire) begin
         sfwd_valid_ff <= stk_we && (SW'(fill_ff) == stk_rd_addr);
      end
   end

   // ---------------------------------------------------------------- stage 1: modify, write back
   kmdes_pkg::key_entry_type key_cur;
   logic [63:0]              elapsed;
   logic                     key_change;
   logic                     slot_valid_n;
   kmdes_pkg::event_type     slot_ev_n;
   logic [FW-1:0]            fill_n;
   logic                     dropped;
   logic                     rvalid;
   kmdes_pkg::event_type     shown;

   assign key_cur = kfwd_valid_ff ? kfwd_data_ff : key_rd;
   assign elapsed = s1_now_ff - key_cur.stamp;
   // Only a key sample may change a key's state.
   assign key_change = (s1_cmd_ff == kmdes_pkg::CMD_SAMPLE) && s1_in_range_ff &&
                       (s1_pressed_ff != key_cur.level) &&
                       (elapsed > {32'd0, lockout_ff});
   assign new_ev = '{row: s1_row_ff, col: s1_col_ff, down: s1_pressed_ff};

   always_comb begin
      slot_valid_n = slot_valid_ff;
      slot_ev_n    = slot_ev_ff;
      fill_n       = fill_ff;
      stk_push     = 1'b0;
      dropped      = 1'b0;
      rvalid       = 1'b0;
      shown        = '0;
      case (s1_cmd_ff)
         kmdes_pkg::CMD_SAMPLE: begin
            if (key_change) begin
               if (!slot_valid_ff) begin
                  slot_valid_n = 1'b1;
                  slot_ev_n    = new_ev;
               end else if (fill_ff < FW'(STACK_DEPTH)) begin
                  stk_push = 1'b1;
                  fill_n   = fill_ff + FW'(1);
               end else begin
                  dropped = 1'b1;
               end
            end
         end
         kmdes_pkg::CMD_END_PASS: begin
            // Refill an empty slot from the stack top.
            if (!slot_valid_ff && (fill_ff != '0)) begin
               fill_n       = fill_ff - FW'(1);
               slot_valid_n = 1'b1;
               slot_ev_n    = sfwd_valid_ff ? sfwd_data_ff : stk_rd_ff;
            end
         end
         kmdes_pkg::CMD_READ: begin
            if (slot_valid_ff) begin
               shown        = slot_ev_ff;
               rvalid       = 1'b1;
               slot_valid_n = 1'b0;
            end
         end
         default: begin
         end
      endcase
      if (!rvalid && slot_valid_n) begin
         shown = slot_ev_n;
      end
   end

   assign key_wr.en   = s1_fire && key_change;
   assign key_wr.data = '{level: s1_pressed_ff, stamp: s1_now_ff};

   assign slot_valid_in = s1_fire ? slot_valid_n : slot_valid_ff;
   assign slot_ev_in    = s1_fire ? slot_ev_n : slot_ev_ff;
   assign fill_in       = s1_fire ? fill_n : fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         slot_ev_ff    <= '0;
         fill_ff       <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         slot_ev_ff    <= slot_ev_in;
         fill_ff       <= fill_in;
      end
   end

   // ---------------------------------------------------------------- response register
   logic                 rsp_valid_ff;
   logic                 rsp_pending_ff;
   kmdes_pkg::event_type rsp_ev_ff;
   logic                 rsp_read_valid_ff;
   logic [5:0]           rsp_count_ff;
   logic                 rsp_dropped_ff;

   // Advance stage 1 when the response register is free or being taken.
   assign s1_fire = s1_valid_ff && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_pending_ff    <= slot_valid_n;
         rsp_ev_ff         <= shown;
         rsp_read_valid_ff <= rvalid;
         rsp_count_ff      <= 6'(fill_n);
         rsp_dropped_ff    <= dropped;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_pending = rsp_pending_ff;
   assign rsp_event_row     = rsp_ev_ff.row;
   assign rsp_event_col     = rsp_ev_ff.col;
   assign rsp_event_down    = rsp_ev_ff.down;
   assign rsp_read_valid    = rsp_read_valid_ff;
   assign rsp_stacked_count = rsp_count_ff;
   assign rsp_event_dropped = rsp_dropped_ff;

endmodule

// ===== rtl/kmdes_checker.sv =====
// Port-level checker of the key matrix debouncer and its bind to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module kmdes_checker #(
   parameter int STACK_DEPTH = 32
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_event_pending,
   input logic [2:0] rsp_event_row,
   input logic [2:0] rsp_event_col,
   input logic       rsp_event_down,
   input logic       rsp_read_valid,
   input logic [5:0] rsp_stacked_count,
   input logic       rsp_event_dropped
);

   // Hold a stalled response beat.
   `KMDES_ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_row) && $stable(rsp_event_col) && $stable(rsp_event_down) && $stable(rsp_read_valid) && $stable(rsp_stacked_count) && $stable(rsp_event_dropped) && $stable(rsp_event_pending))

   // A successful read empties the slot.
   `KMDES_ASSERT_CLK(a_read_empties, rsp_valid && rsp_read_valid |-> !rsp_event_pending && !rsp_event_dropped)

   // Drop only with a full stack and an occupied slot.
   `KMDES_ASSERT_CLK(a_drop_full, rsp_valid && rsp_event_dropped |-> rsp_event_pending && (rsp_stacked_count == 6'(STACK_DEPTH)))

   // No event to show leaves the event fields at zero.
   `KMDES_ASSERT_CLK(a_idle_fields, rsp_valid && !rsp_event_pending && !rsp_read_valid |-> (rsp_event_row == 3'd0) && (rsp_event_col == 3'd0) && !rsp_event_down)

endmodule

bind key_matrix_debounce_event_stack kmdes_checker #(
   .STACK_DEPTH (STACK_DEPTH)
) u_kmdes_checker (.*);
